[sv/rvdec_pkg.sv]
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and codes for the RV32I instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

    localparam int unsigned InstrWidth = 32;
    localparam int unsigned RegWidth   = 5;

    // Major opcodes, bits 6:0
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_ALUI   = 7'b0010011;
    localparam logic [6:0] OPC_ALUR   = 7'b0110011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;

    typedef enum logic [2:0] {
        CLS_LOAD   = 3'd0,
        CLS_STORE  = 3'd1,
        CLS_ALUI   = 3'd2,
        CLS_ALUR   = 3'd3,
        CLS_BRANCH = 3'd4,
        CLS_JUMP   = 3'd5
    } t_class;

    typedef enum logic [5:0] {
        OP_LB    = 6'd0,  OP_LH    = 6'd1,  OP_LW    = 6'd2,  OP_LBU   = 6'd3,
        OP_LHU   = 6'd4,  OP_SB    = 6'd5,  OP_SH    = 6'd6,  OP_SW    = 6'd7,
        OP_ADDI  = 6'd8,  OP_SLTI  = 6'd9,  OP_SLTIU = 6'd10, OP_XORI  = 6'd11,
        OP_ORI   = 6'd12, OP_ANDI  = 6'd13, OP_SLLI  = 6'd14, OP_SRLI  = 6'd15,
        OP_SRAI  = 6'd16, OP_ADD   = 6'd17, OP_SUB   = 6'd18, OP_SLL   = 6'd19,
        OP_SLT   = 6'd20, OP_SLTU  = 6'd21, OP_XOR   = 6'd22, OP_SRL   = 6'd23,
        OP_SRA   = 6'd24, OP_OR    = 6'd25, OP_AND   = 6'd26, OP_BEQ   = 6'd27,
        OP_BNE   = 6'd28, OP_BLT   = 6'd29, OP_BGE   = 6'd30, OP_BLTU  = 6'd31,
        OP_BGEU  = 6'd32, OP_JAL   = 6'd33, OP_JALR  = 6'd34, OP_AUIPC = 6'd35,
        OP_LUI   = 6'd36
    } t_op;

    typedef struct packed {
        t_class                     instr_class;
        t_op                        operation;
        logic [RegWidth-1:0]        dest_reg;
        logic [RegWidth-1:0]        src_reg_a;
        logic [RegWidth-1:0]        src_reg_b;
        logic signed [InstrWidth-1:0] immediate;
        logic                       illegal;
    } t_dec;

endpackage

[sv/rvdec_decode.sv]
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational RV32I decode of one instruction word into class, operation,
// register numbers, immediate and illegal flag.
// ----------------------------------------------------------------------------
module rvdec_decode (
    input  logic [rvdec_pkg::InstrWidth-1:0] i_instr,
    output rvdec_pkg::t_dec                  o_dec
);
    import rvdec_pkg::*;

    // funct3 codes
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;
    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh;
    t_class      cls;
    t_op         op;
    logic [31:0] imm;
    logic        bad;

    assign opc = i_instr[6:0];
    assign f3  = i_instr[14:12];
    assign f7  = i_instr[31:25];

    assign imm_i  = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s  = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b  = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                     i_instr[11:8], 1'b0};
    assign imm_j  = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                     i_instr[30:21], 1'b0};
    assign imm_u  = {i_instr[31:12], 12'd0};
    assign imm_sh = {27'd0, i_instr[24:20]};

    always_comb begin
        cls = CLS_JUMP;
        op  = OP_LB;
        imm = '0;
        bad = 1'b0;
        unique case (opc)
            OPC_LOAD: begin
                cls = CLS_LOAD;
                imm = imm_i;
                unique case (f3)
                    F3_0:    op = OP_LB;
                    F3_1:    op = OP_LH;
                    F3_2:    op = OP_LW;
                    F3_4:    op = OP_LBU;
                    F3_5:    op = OP_LHU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_STORE: begin
                cls = CLS_STORE;
                imm = imm_s;
                unique case (f3)
                    F3_0:    op = OP_SB;
                    F3_1:    op = OP_SH;
                    F3_2:    op = OP_SW;
                    default: bad = 1'b1;
                endcase
            end
            OPC_ALUI: begin
                cls = CLS_ALUI;
                imm = imm_i;
                unique case (f3)
                    F3_0: op = OP_ADDI;
                    F3_2: op = OP_SLTI;
                    F3_3: op = OP_SLTIU;
                    F3_4: op = OP_XORI;
                    F3_6: op = OP_ORI;
                    F3_7: op = OP_ANDI;
                    F3_1: begin
                        imm = imm_sh;
                        if (f7 == F7_BASE) op = OP_SLLI;
                        else               bad = 1'b1;
                    end
                    F3_5: begin
                        imm = imm_sh;
                        if (f7 == F7_BASE)     op = OP_SRLI;
                        else if (f7 == F7_ALT) op = OP_SRAI;
                        else                   bad = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            OPC_ALUR: begin
                cls = CLS_ALUR;
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        F3_0:    op = OP_ADD;
                        F3_1:    op = OP_SLL;
                        F3_2:    op = OP_SLT;
                        F3_3:    op = OP_SLTU;
                        F3_4:    op = OP_XOR;
                        F3_5:    op = OP_SRL;
                        F3_6:    op = OP_OR;
                        default: op = OP_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_0) begin
                    op = OP_SUB;
                end else if (f7 == F7_ALT && f3 == F3_5) begin
                    op = OP_SRA;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_BRANCH: begin
                cls = CLS_BRANCH;
                imm = imm_b;
                unique case (f3)
                    F3_0:    op = OP_BEQ;
                    F3_1:    op = OP_BNE;
                    F3_4:    op = OP_BLT;
                    F3_5:    op = OP_BGE;
                    F3_6:    op = OP_BLTU;
                    F3_7:    op = OP_BGEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_JAL: begin
                op  = OP_JAL;
                imm = imm_j;
            end
            OPC_JALR: begin
                op  = OP_JALR;
                imm = imm_i;
                if (f3 != F3_0) bad = 1'b1;
            end
            OPC_AUIPC: begin
                op  = OP_AUIPC;
                imm = imm_u;
            end
            OPC_LUI: begin
                op  = OP_LUI;
                imm = imm_u;
            end
            default: bad = 1'b1;
        endcase
        // illegal words report operation 0 and a zero immediate
        if (bad) begin
            op  = OP_LB;
            imm = '0;
        end
    end

    always_comb begin
        o_dec.instr_class = cls;
        o_dec.operation   = op;
        o_dec.dest_reg    = i_instr[11:7];
        o_dec.src_reg_a   = i_instr[19:15];
        o_dec.src_reg_b   = i_instr[24:20];
        o_dec.immediate   = signed'(imm);
        o_dec.illegal     = bad;
    end

endmodule

[sv/rv32i_instruction_decoder_top.sv]
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_top
// RV32I instruction decoder: input register, decode logic, result register.
// ----------------------------------------------------------------------------
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------------
//  command   | start / busy     | i_instruction
//  result    | o_strobe         | o_instr_class, o_operation, o_dest_reg,
//            |                  | o_src_reg_a, o_src_reg_b, o_immediate,
//            |                  | o_illegal
//
//  - One word per cycle: busy stays low, a word can be started every cycle.
//  - Each word passes start edge -> input register -> result register;
//    o_strobe is high for exactly one cycle per word.
//  - The decode stage (one level of opcode/funct muxing) sets the cycle time.
//  - Synchronous active-low reset clears both valid flags; payload is not reset.
//  - Results cannot be stalled by the receiver, so nothing backs up.
//
module rv32i_instruction_decoder_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [rvdec_pkg::InstrWidth-1:0]       i_instruction,
    output logic                                   o_strobe,
    output logic [2:0]                             o_instr_class,
    output logic [5:0]                             o_operation,
    output logic [rvdec_pkg::RegWidth-1:0]         o_dest_reg,
    output logic [rvdec_pkg::RegWidth-1:0]         o_src_reg_a,
    output logic [rvdec_pkg::RegWidth-1:0]         o_src_reg_b,
    output logic signed [rvdec_pkg::InstrWidth-1:0] o_immediate,
    output logic                                   o_illegal
);
    import rvdec_pkg::*;

    logic                  r_in_valid, n_in_valid;
    logic [InstrWidth-1:0] r_instr;
    logic                  r_out_valid, n_out_valid;
    t_dec                  r_dec;
    t_dec                  dec;
    logic                  accept;

    // fully pipelined: never refuses a word
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign n_in_valid  = accept;
    assign n_out_valid = r_in_valid;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (accept) begin
            r_instr <= i_instruction;
        end
    end

    rvdec_decode u_decode (
        .i_instr (r_instr),
        .o_dec   (dec)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (r_in_valid) begin
            r_dec <= dec;
        end
    end

    assign o_strobe      = r_out_valid;
    assign o_instr_class = r_dec.instr_class;
    assign o_operation   = r_dec.operation;
    assign o_dest_reg    = r_dec.dest_reg;
    assign o_src_reg_a   = r_dec.src_reg_a;
    assign o_src_reg_b   = r_dec.src_reg_b;
    assign o_immediate   = r_dec.immediate;
    assign o_illegal     = r_dec.illegal;

`ifndef SYNTH
    // every result traces back to a start through the input and result registers
    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 2))
        else $error("result strobe without matching start");

    // an accepted word always produces a strobe after the input and result registers
    a_start_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("accepted word produced no result");

    // illegal words carry zero operation and immediate
    a_illegal_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_illegal) |-> (o_operation == OP_LB && o_immediate == '0))
        else $error("illegal word with nonzero operation or immediate");

    // register-register operations have no immediate
    a_alur_no_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_instr_class == CLS_ALUR) |-> (o_immediate == '0))
        else $error("register-register operation with nonzero immediate");

    // upper-immediate operations keep the low 12 bits clear
    a_upper_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_illegal && (o_operation == OP_LUI || o_operation == OP_AUIPC))
        |-> (o_immediate[11:0] == 12'd0))
        else $error("upper immediate has low bits set");
`endif

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RV32I instruction decoder. A short table of
// hand-picked words (format extremes, bad opcodes, bad funct fields) runs
// first, then about a thousand random words, most of them legal encodings of
// a randomly chosen operation, the rest corrupted or raw noise. Every result
// is checked field by field against its typed-in row or the decode model below.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rvdec_pkg::*;

    localparam int N_RAND = 1000;
    localparam int N_TAIL = 150;    // last words go in back to back

    // funct3 codes, shared by the encoder and the decode model
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SR  = 3'd5, F3_OR  = 3'd6, F3_AND  = 3'd7;
    localparam logic [2:0] F3_B   = 3'd0, F3_H   = 3'd1, F3_W   = 3'd2;
    localparam logic [2:0] F3_BU  = 3'd4, F3_HU  = 3'd5;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7, F3_JALR = 3'd0;
    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000, F7_ALT = 7'b0100000;

    // one row of the directed table: word, flag for a typed-in result, result
    typedef struct packed {
        logic [31:0] word;
        logic        has_exp;
        t_dec        exp;
    } t_row;

    localparam logic [$bits(t_dec):0] NO_EXP = '0;
    localparam int N_DIR = 27;

    t_row dir_rows [N_DIR] = '{
        // all zeros and all ones: unknown opcodes
        {32'h00000000, 1'b1, CLS_JUMP,   OP_LB,  5'd0,  5'd0,  5'd0,  32'h0,        1'b1},
        {32'hFFFFFFFF, 1'b1, CLS_JUMP,   OP_LB,  5'd31, 5'd31, 5'd31, 32'h0,        1'b1},
        // opcode whose low two bits are not 11
        {32'h00000011, 1'b1, CLS_JUMP,   OP_LB,  5'd0,  5'd0,  5'd0,  32'h0,        1'b1},
        // LB with the most negative offset, LBU with the most positive
        {32'h80010083, 1'b1, CLS_LOAD,   OP_LB,  5'd1,  5'd2,  5'd0,  32'hFFFFF800, 1'b0},
        {32'h7FF0C203, 1'b1, CLS_LOAD,   OP_LBU, 5'd4,  5'd1,  5'd31, 32'h000007FF, 1'b0},
        // loads with undefined widths
        {32'h00003003, 1'b1, CLS_LOAD,   OP_LB,  5'd0,  5'd0,  5'd0,  32'h0,        1'b1},
        {32'h00006003, NO_EXP},
        {32'h00007003, NO_EXP},
        // store with an undefined width, SW with offset -1
        {32'h00003023, 1'b1, CLS_STORE,  OP_LB,  5'd0,  5'd0,  5'd0,  32'h0,        1'b1},
        {32'hFE002FA3, NO_EXP},
        // ADDI max, SLLI by 31, SLLI with funct7 set
        {32'h7FFF8F93, NO_EXP},
        {32'h01F09093, NO_EXP},
        {32'h02009093, 1'b1, CLS_ALUI,   OP_LB,  5'd1,  5'd1,  5'd0,  32'h0,        1'b1},
        // SRAI by 0, right shift with a bad funct7
        {32'h4000D093, NO_EXP},
        {32'hFFF0D093, NO_EXP},
        // SUB, SLL with the alternate funct7, SRA, multiply-extension word
        {32'h40000033, NO_EXP},
        {32'h40001033, 1'b1, CLS_ALUR,   OP_LB,  5'd0,  5'd0,  5'd0,  32'h0,        1'b1},
        {32'h4020D0B3, NO_EXP},
        {32'h02000033, NO_EXP},
        // branch offsets -2 and -4096, undefined branch conditions
        {32'hFE000FE3, NO_EXP},
        {32'h80000063, NO_EXP},
        {32'h00002063, 1'b1, CLS_BRANCH, OP_LB,  5'd0,  5'd0,  5'd0,  32'h0,        1'b1},
        {32'h00003063, NO_EXP},
        // JAL extremes, JALR with nonzero funct3
        {32'h800000EF, NO_EXP},
        {32'h7FFFF06F, NO_EXP},
        {32'h00001067, 1'b1, CLS_JUMP,   OP_LB,  5'd0,  5'd0,  5'd0,  32'h0,        1'b1},
        // upper immediates
        {32'hFFFFF097, NO_EXP}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_instruction;
    logic        o_strobe;
    logic [2:0]  o_instr_class;
    logic [5:0]  o_operation;
    logic [4:0]  o_dest_reg;
    logic [4:0]  o_src_reg_a;
    logic [4:0]  o_src_reg_b;
    logic signed [31:0] o_immediate;
    logic        o_illegal;

    // travels with the word being offered: use a typed-in result instead
    logic        row_typed;
    t_dec        row_exp;

    t_dec        pending_dec[$];    // decodes still owed by the block
    int          n_err = 0;
    int          n_words = 0;
    int          n_bad = 0;
    logic [36:0] ops_hit = '0;

    rv32i_instruction_decoder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_instruction (i_instruction),
        .o_strobe      (o_strobe),
        .o_instr_class (o_instr_class),
        .o_operation   (o_operation),
        .o_dest_reg    (o_dest_reg),
        .o_src_reg_a   (o_src_reg_a),
        .o_src_reg_b   (o_src_reg_b),
        .o_immediate   (o_immediate),
        .o_illegal     (o_illegal)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decode model: what the block should make of one word.
    // Illegal words keep class and register fields, zero op and immediate.
    // ------------------------------------------------------------------------
    function automatic t_dec decode_word(input logic [31:0] w);
        t_dec        d;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        bad;
        logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, shamt;
        f3    = w[14:12];
        f7    = w[31:25];
        bad   = 1'b0;
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        imm_u = {w[31:12], 12'b0};
        shamt = {27'b0, w[24:20]};
        d.instr_class = CLS_JUMP;
        d.operation   = OP_LB;
        d.immediate   = '0;
        d.dest_reg    = w[11:7];
        d.src_reg_a   = w[19:15];
        d.src_reg_b   = w[24:20];
        case (w[6:0])
            OPC_LOAD: begin
                d.instr_class = CLS_LOAD;
                d.immediate   = imm_i;
                case (f3)
                    F3_B:    d.operation = OP_LB;
                    F3_H:    d.operation = OP_LH;
                    F3_W:    d.operation = OP_LW;
                    F3_BU:   d.operation = OP_LBU;
                    F3_HU:   d.operation = OP_LHU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_STORE: begin
                d.instr_class = CLS_STORE;
                d.immediate   = imm_s;
                case (f3)
                    F3_B:    d.operation = OP_SB;
                    F3_H:    d.operation = OP_SH;
                    F3_W:    d.operation = OP_SW;
                    default: bad = 1'b1;
                endcase
            end
            OPC_ALUI: begin
                d.instr_class = CLS_ALUI;
                d.immediate   = imm_i;
                case (f3)
                    F3_ADD:  d.operation = OP_ADDI;
                    F3_SLT:  d.operation = OP_SLTI;
                    F3_SLTU: d.operation = OP_SLTIU;
                    F3_XOR:  d.operation = OP_XORI;
                    F3_OR:   d.operation = OP_ORI;
                    F3_AND:  d.operation = OP_ANDI;
                    F3_SLL: begin
                        d.immediate = shamt;
                        if (f7 == F7_BASE) d.operation = OP_SLLI;
                        else bad = 1'b1;
                    end
                    default: begin
                        d.immediate = shamt;
                        if (f7 == F7_BASE) d.operation = OP_SRLI;
                        else if (f7 == F7_ALT) d.operation = OP_SRAI;
                        else bad = 1'b1;
                    end
                endcase
            end
            OPC_ALUR: begin
                d.instr_class = CLS_ALUR;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  d.operation = OP_ADD;
                        F3_SLL:  d.operation = OP_SLL;
                        F3_SLT:  d.operation = OP_SLT;
                        F3_SLTU: d.operation = OP_SLTU;
                        F3_XOR:  d.operation = OP_XOR;
                        F3_SR:   d.operation = OP_SRL;
                        F3_OR:   d.operation = OP_OR;
                        default: d.operation = OP_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    d.operation = OP_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    d.operation = OP_SRA;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_BRANCH: begin
                d.instr_class = CLS_BRANCH;
                d.immediate   = imm_b;
                case (f3)
                    F3_BEQ:  d.operation = OP_BEQ;
                    F3_BNE:  d.operation = OP_BNE;
                    F3_BLT:  d.operation = OP_BLT;
                    F3_BGE:  d.operation = OP_BGE;
                    F3_BLTU: d.operation = OP_BLTU;
                    F3_BGEU: d.operation = OP_BGEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_JAL: begin
                d.operation = OP_JAL;
                d.immediate = imm_j;
            end
            OPC_JALR: begin
                d.immediate = imm_i;
                if (f3 == F3_JALR) d.operation = OP_JALR;
                else bad = 1'b1;
            end
            OPC_AUIPC: begin
                d.operation = OP_AUIPC;
                d.immediate = imm_u;
            end
            OPC_LUI: begin
                d.operation = OP_LUI;
                d.immediate = imm_u;
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            d.operation = OP_LB;
            d.immediate = '0;
        end
        d.illegal = bad;
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Encoder: a legal word for the given operation, all other bits random.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] encode_op(input t_op op);
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        fix_f7;
        w      = $urandom();
        f3     = w[14:12];
        f7     = F7_BASE;
        fix_f7 = 1'b0;
        case (op)
            OP_LB:    begin opc = OPC_LOAD;  f3 = F3_B;  end
            OP_LH:    begin opc = OPC_LOAD;  f3 = F3_H;  end
            OP_LW:    begin opc = OPC_LOAD;  f3 = F3_W;  end
            OP_LBU:   begin opc = OPC_LOAD;  f3 = F3_BU; end
            OP_LHU:   begin opc = OPC_LOAD;  f3 = F3_HU; end
            OP_SB:    begin opc = OPC_STORE; f3 = F3_B;  end
            OP_SH:    begin opc = OPC_STORE; f3 = F3_H;  end
            OP_SW:    begin opc = OPC_STORE; f3 = F3_W;  end
            OP_ADDI:  begin opc = OPC_ALUI;  f3 = F3_ADD;  end
            OP_SLTI:  begin opc = OPC_ALUI;  f3 = F3_SLT;  end
            OP_SLTIU: begin opc = OPC_ALUI;  f3 = F3_SLTU; end
            OP_XORI:  begin opc = OPC_ALUI;  f3 = F3_XOR;  end
            OP_ORI:   begin opc = OPC_ALUI;  f3 = F3_OR;   end
            OP_ANDI:  begin opc = OPC_ALUI;  f3 = F3_AND;  end
            OP_SLLI:  begin opc = OPC_ALUI;  f3 = F3_SLL; fix_f7 = 1'b1; end
            OP_SRLI:  begin opc = OPC_ALUI;  f3 = F3_SR;  fix_f7 = 1'b1; end
            OP_SRAI:  begin opc = OPC_ALUI;  f3 = F3_SR;  fix_f7 = 1'b1; f7 = F7_ALT; end
            OP_ADD:   begin opc = OPC_ALUR;  f3 = F3_ADD;  fix_f7 = 1'b1; end
            OP_SUB:   begin opc = OPC_ALUR;  f3 = F3_ADD;  fix_f7 = 1'b1; f7 = F7_ALT; end
            OP_SLL:   begin opc = OPC_ALUR;  f3 = F3_SLL;  fix_f7 = 1'b1; end
            OP_SLT:   begin opc = OPC_ALUR;  f3 = F3_SLT;  fix_f7 = 1'b1; end
            OP_SLTU:  begin opc = OPC_ALUR;  f3 = F3_SLTU; fix_f7 = 1'b1; end
            OP_XOR:   begin opc = OPC_ALUR;  f3 = F3_XOR;  fix_f7 = 1'b1; end
            OP_SRL:   begin opc = OPC_ALUR;  f3 = F3_SR;   fix_f7 = 1'b1; end
            OP_SRA:   begin opc = OPC_ALUR;  f3 = F3_SR;   fix_f7 = 1'b1; f7 = F7_ALT; end
            OP_OR:    begin opc = OPC_ALUR;  f3 = F3_OR;   fix_f7 = 1'b1; end
            OP_AND:   begin opc = OPC_ALUR;  f3 = F3_AND;  fix_f7 = 1'b1; end
            OP_BEQ:   begin opc = OPC_BRANCH; f3 = F3_BEQ;  end
            OP_BNE:   begin opc = OPC_BRANCH; f3 = F3_BNE;  end
            OP_BLT:   begin opc = OPC_BRANCH; f3 = F3_BLT;  end
            OP_BGE:   begin opc = OPC_BRANCH; f3 = F3_BGE;  end
            OP_BLTU:  begin opc = OPC_BRANCH; f3 = F3_BLTU; end
            OP_BGEU:  begin opc = OPC_BRANCH; f3 = F3_BGEU; end
            OP_JAL:   opc = OPC_JAL;
            OP_JALR:  begin opc = OPC_JALR;  f3 = F3_JALR; end
            OP_AUIPC: opc = OPC_AUIPC;
            default:  opc = OPC_LUI;
        endcase
        w[6:0]   = opc;
        w[14:12] = f3;
        if (fix_f7) w[31:25] = f7;
        return w;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, i.e. the values that
    // held during the cycle that edge closes. Results are checked before the
    // new word is queued, so a word never pairs with its own result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dec want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_dec.size() == 0) begin
                    $error("result strobe with no word outstanding");
                    n_err++;
                end else begin
                    want = pending_dec.pop_front();
                    check_field("instr_class", want.instr_class, o_instr_class);
                    check_field("operation",   want.operation,   o_operation);
                    check_field("dest_reg",    want.dest_reg,    o_dest_reg);
                    check_field("src_reg_a",   want.src_reg_a,   o_src_reg_a);
                    check_field("src_reg_b",   want.src_reg_b,   o_src_reg_b);
                    check_field("immediate",   want.immediate,   o_immediate);
                    check_field("illegal",     want.illegal,     o_illegal);
                end
            end
            if (start && !busy) begin
                want = row_typed ? row_exp : decode_word(i_instruction);
                pending_dec.push_back(want);
                n_words++;
                if (want.illegal) n_bad++;
                else ops_hit[want.operation] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: inputs move on the falling edge only.
    // ------------------------------------------------------------------------
    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_instruction <= $urandom();  // junk on the bus while idle
        end
    endtask

    // offer one word and hold it until the decoder takes it
    task automatic send_word(input logic [31:0] w, input logic typed, input t_dec exp);
        @(negedge i_clk);
        start         <= 1'b1;
        i_instruction <= w;
        row_typed     <= typed;
        row_exp       <= exp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] w;
        int          pick;
        logic        idle_on;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_instruction = '0;
        row_typed     = 1'b0;
        row_exp       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < N_DIR; k++) begin
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 5));
            send_word(dir_rows[k].word, dir_rows[k].has_exp, dir_rows[k].exp);
        end

        // random part: mostly legal words, mixed with corrupted ones and noise
        for (int k = 0; k < N_RAND; k++) begin
            // idle in some stretches only, and never in the tail
            idle_on = (k < N_RAND - N_TAIL) && ((k / 80) % 4 != 3);
            if (idle_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 5));
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                w = encode_op(t_op'($urandom_range(0, 36)));
            end else if (pick < 90) begin
                w = encode_op(t_op'($urandom_range(0, 36)));
                case ($urandom_range(0, 2))
                    0:       w[31:25] = w[31:25] ^ 7'($urandom_range(1, 127));
                    1:       w[14:12] = 3'($urandom());
                    default: w[6:0]   = 7'($urandom());
                endcase
            end else begin
                w = $urandom();
            end
            send_word(w, 1'b0, '0);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // drain, then keep watching to catch stray strobes
        while (pending_dec.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Decoded %0d words, %0d of them illegal.", n_words, n_bad);
        $display("Legal operations exercised: %0d of 37.", $countones(ops_hit));
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hang guard: stops a run that never finishes and reports it as a failure
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
